### src/assert_macros.svh
// assertion helpers, sampled on the block clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TNF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked during reset as well
`define TNF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### src/tnf_pkg.sv
`default_nettype none

package tnf_pkg;

    // widths of the arithmetic path
    typedef logic signed [20:0] t_mc;     // signed millicents
    typedef logic [20:0]        t_res;    // millicents folded into one octave
    typedef logic [29:0]        t_y;      // exponent argument, Q0.30
    typedef logic [30:0]        t_q30;    // ratio, Q1.30
    typedef logic [29:0]        t_base;   // reference in micro-hertz
    typedef logic [5:0]         t_shift;
    typedef logic [23:0]        t_freq;

    typedef enum logic [1:0] {
        REG_REF_A  = 2'd0,
        REG_TEMPER = 2'd1,
        REG_ROOT   = 2'd2,
        REG_DRIVE  = 2'd3
    } t_reg_idx;

    // data that rides alongside the exponential
    typedef struct packed {
        logic [3:0] pc;
        logic [3:0] oct;
        t_shift     sh;
        t_base      b0;
    } t_side;

    localparam t_res        MC_PER_OCTAVE = 21'd1200000;
    localparam t_mc         DETUNE_SCALE  = 21'sd1000;
    localparam logic [16:0] REF_SCALE     = 17'd100000;
    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam t_q30        Q30_ONE       = 31'd1073741824;
    localparam logic [19:0] Y_ROUND       = 20'd600000;
    localparam logic [13:0] Y_DIV         = 14'd9375;
    localparam logic [14:0] Y_DIV2        = 15'd18750;
    localparam logic [31:0] Y_RECIP       = 32'd3752999689;
    localparam logic [8:0]  HALF_MHZ      = 9'd500;
    localparam logic [40:0] SAT_LIMIT     = 41'd16777216000;
    localparam logic [6:0]  MHZ_DIV       = 7'd125;
    localparam logic [31:0] MHZ_RECIP     = 32'd2199023255;
    localparam t_freq       FREQ_MAX      = 24'hFFFFFF;

    localparam int unsigned EXP_TERMS    = 12;
    localparam int unsigned EXP_STEP_LAT = 3;

    localparam t_mc TEMPER_ROM [6][12] = '{
        '{-21'sd900000, -21'sd800000, -21'sd700000, -21'sd600000, -21'sd500000,
          -21'sd400000, -21'sd300000, -21'sd200000, -21'sd100000, 21'sd0,
          21'sd100000, 21'sd200000},
        '{-21'sd889700, -21'sd813700, -21'sd696500, -21'sd579400, -21'sd503400,
          -21'sd386300, -21'sd310200, -21'sd192900, -21'sd117100, 21'sd0,
          21'sd117100, 21'sd193200},
        '{-21'sd888270, -21'sd798045, -21'sd696090, -21'sd594135, -21'sd498045,
          -21'sd390225, -21'sd300000, -21'sd192180, -21'sd96090, 21'sd0,
          21'sd107820, 21'sd203910},
        '{-21'sd893800, -21'sd799900, -21'sd698000, -21'sd596000, -21'sd502100,
          -21'sd393900, -21'sd301900, -21'sd195900, -21'sd98000, 21'sd0,
          21'sd106000, 21'sd198000},
        '{-21'sd905900, -21'sd792200, -21'sd702000, -21'sd611800, -21'sd498100,
          -21'sd407900, -21'sd294200, -21'sd203900, -21'sd113700, 21'sd0,
          21'sd90200, 21'sd203900},
        '{-21'sd891000, -21'sd792000, -21'sd693000, -21'sd594000, -21'sd495000,
          -21'sd396000, -21'sd297000, -21'sd198000, -21'sd99000, 21'sd0,
          21'sd99000, 21'sd198000}
    };

    // unknown temperament rows fall back to equal temperament
    function automatic t_mc temper_lookup(input logic [2:0] sel, input logic [3:0] pc);
        logic [2:0] row;
        logic [3:0] col;
        row = (sel > 3'd5) ? 3'd0 : sel;
        col = (pc > 4'd11) ? 4'd0 : pc;
        return TEMPER_ROM[row][col];
    endfunction

    // floor(2^33 / k) for the divide-by-term step
    function automatic logic [31:0] exp_recip(input int unsigned k);
        logic [31:0] m;
        case (k)
            3:       m = 32'd2863311530;
            4:       m = 32'd2147483648;
            5:       m = 32'd1717986918;
            6:       m = 32'd1431655765;
            7:       m = 32'd1227133513;
            8:       m = 32'd1073741824;
            9:       m = 32'd954437176;
            10:      m = 32'd858993459;
            11:      m = 32'd780903144;
            12:      m = 32'd715827882;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### src/tnf_front.sv
`default_nettype none

module tnf_front import tnf_pkg::*; #(
    parameter int unsigned LOWEST_OCTAVE = 2,
    parameter int unsigned NOTE_SPAN     = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [5:0]        i_note,
    input  wire logic signed [6:0] i_detune,
    input  wire logic [12:0]       i_ref,
    input  wire logic [2:0]        i_sel,
    input  wire logic [3:0]        i_root,
    output logic                   o_valid,
    output t_y                     o_y,
    output t_side                  o_side
);

    localparam int unsigned SUM_W = $clog2(NOTE_SPAN + 15);

    // stage 1: pitch class and octave
    logic [6:0]       note_c;
    logic [SUM_W-1:0] sum;
    logic [SUM_W+5:0] q_prod;
    logic [SUM_W-4:0] q_oct;
    logic [4:0]       n_oct1;
    logic [3:0]       n_pc1;

    assign note_c = (7'(i_note) >= 7'(NOTE_SPAN)) ? 7'(NOTE_SPAN - 1) : 7'(i_note);
    assign sum    = SUM_W'(note_c + 7'(i_root));
    // sum / 12 as sum * 43 / 512, exact below 128
    assign q_prod = (SUM_W + 6)'(sum) * (SUM_W + 6)'(43);
    assign q_oct  = q_prod[SUM_W+5:9];
    assign n_oct1 = 5'(q_oct) + 5'(LOWEST_OCTAVE);
    assign n_pc1  = 4'(sum - SUM_W'(q_oct * SUM_W'(12)));

    logic              r_v1;
    logic [4:0]        r_oct1;
    logic [3:0]        r_pc1;
    logic signed [6:0] r_det1;

    // stage 2: temperament offset folded into one octave
    t_mc   m_sum;
    t_res  m_u;
    t_res  n_res2;
    t_side n_side2;

    assign m_sum  = temper_lookup(i_sel, r_pc1) + t_mc'(r_det1) * DETUNE_SCALE;
    assign m_u    = m_sum;
    assign n_res2 = m_sum[20] ? m_u + MC_PER_OCTAVE : m_u;

    always_comb begin
        n_side2.pc  = r_pc1;
        n_side2.oct = r_oct1[3:0];
        // total right shift of the product: 30 + octave borrow - (octave - 4)
        n_side2.sh  = 6'd34 + 6'(m_sum[20]) - 6'(r_oct1);
        n_side2.b0  = 30'(i_ref) * 30'(REF_SCALE);
    end

    logic  r_v2;
    t_res  r_res2;
    t_side r_side2;

    // stage 3: residue times ln2, rounded
    logic [49:0] y_num;
    assign y_num = 50'(r_res2) * 50'(LN2_Q30) + 50'(Y_ROUND);

    logic        r_v3;
    logic [42:0] r_tq3;
    t_side       r_side3;

    // stage 4: quotient estimate by reciprocal
    logic [61:0] qe_prod;
    assign qe_prod = 62'(r_tq3[42:13]) * 62'(Y_RECIP);

    logic        r_v4;
    logic [42:0] r_tq4;
    logic [29:0] r_qe4;
    t_side       r_side4;

    // stage 5: correct the estimate by up to two
    logic [42:0] rem5;
    t_y          n_y5;
    assign rem5 = r_tq4 - 43'(r_qe4) * 43'(Y_DIV);

    always_comb begin
        if (rem5 >= 43'(Y_DIV2)) begin
            n_y5 = r_qe4 + 30'd2;
        end else if (rem5 >= 43'(Y_DIV)) begin
            n_y5 = r_qe4 + 30'd1;
        end else begin
            n_y5 = r_qe4;
        end
    end

    logic  r_v5;
    t_y    r_y5;
    t_side r_side5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct1  <= n_oct1;
        r_pc1   <= n_pc1;
        r_det1  <= i_detune;
        r_res2  <= n_res2;
        r_side2 <= n_side2;
        r_tq3   <= y_num[49:7];
        r_side3 <= r_side2;
        r_tq4   <= r_tq3;
        r_qe4   <= qe_prod[61:32];
        r_side4 <= r_side3;
        r_y5    <= n_y5;
        r_side5 <= r_side4;
    end

    assign o_valid = r_v5;
    assign o_y     = r_y5;
    assign o_side  = r_side5;

endmodule

`default_nettype wire

### src/tnf_exp_step.sv
`default_nettype none

module tnf_exp_step import tnf_pkg::*; #(
    parameter int unsigned K = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_q30      i_p,
    input  t_y        i_y,
    output logic      o_valid,
    output t_q30      o_p,
    output t_y        o_y
);

    localparam logic [31:0] RECIP = exp_recip(K);

    // stage a: p * y in Q1.30
    logic [60:0] prod_a;
    assign prod_a = 61'(i_p) * 61'(i_y);

    logic        r_va;
    logic [30:0] r_wa;
    t_y          r_ya;

    // stage b: estimate of w / k
    logic [30:0] n_qe;

    generate
        if (K < 3) begin : g_shift
            assign n_qe = r_wa >> $clog2(K);
        end else begin : g_recip
            logic [62:0] prod_b;
            assign prod_b = 63'(r_wa) * 63'(RECIP);
            assign n_qe   = 31'(prod_b[62:33]);
        end
    endgenerate

    logic        r_vb;
    logic [30:0] r_wb;
    logic [30:0] r_qe;
    t_y          r_yb;

    // stage c: fix the estimate, add one
    logic [30:0] rem_c;
    t_q30        n_p;
    assign rem_c = r_wb - r_qe * 31'(K);
    assign n_p   = Q30_ONE + r_qe + 31'(rem_c >= 31'(K));

    logic r_vc;
    t_q30 r_pc;
    t_y   r_yc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= prod_a[60:30];
        r_ya <= i_y;
        r_wb <= r_wa;
        r_qe <= n_qe;
        r_yb <= r_ya;
        r_pc <= n_p;
        r_yc <= r_yb;
    end

    assign o_valid = r_vc;
    assign o_p     = r_pc;
    assign o_y     = r_yc;

endmodule

`default_nettype wire

### src/tnf_exp.sv
`default_nettype none

module tnf_exp import tnf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_y        i_y,
    output logic      o_valid,
    output t_q30      o_ratio
);

    // horner chain for e^y, highest term first
    logic v_chain [EXP_TERMS+1];
    t_q30 p_chain [EXP_TERMS+1];
    t_y   y_chain [EXP_TERMS+1];

    assign v_chain[0] = i_valid;
    assign p_chain[0] = Q30_ONE;
    assign y_chain[0] = i_y;

    generate
        for (genvar i = 0; i < EXP_TERMS; i++) begin : g_term
            tnf_exp_step #(
                .K (EXP_TERMS - i)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (v_chain[i]),
                .i_p     (p_chain[i]),
                .i_y     (y_chain[i]),
                .o_valid (v_chain[i+1]),
                .o_p     (p_chain[i+1]),
                .o_y     (y_chain[i+1])
            );
        end
    endgenerate

    assign o_valid = v_chain[EXP_TERMS];
    assign o_ratio = p_chain[EXP_TERMS];

endmodule

`default_nettype wire

### src/tnf_scale.sv
`default_nettype none

module tnf_scale import tnf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_q30      i_ratio,
    input  t_side     i_side,
    input  wire logic i_drive,
    output logic      o_valid,
    output logic [3:0] o_pc,
    output logic [3:0] o_oct,
    output t_freq     o_freq,
    output t_freq     o_drive_speed
);

    // stage m: reference times ratio
    logic        r_vm;
    logic [60:0] r_prod;
    t_shift      r_shm;
    logic [3:0]  r_pcm;
    logic [3:0]  r_octm;

    // stage s: octave shift, rounding offset, saturation
    logic [60:0] shifted;
    logic [40:0] v_round;
    assign shifted = r_prod >> r_shm;
    assign v_round = 41'(shifted[39:0]) + 41'(HALF_MHZ);

    logic        r_vs;
    logic        r_sats;
    logic [30:0] r_v8s;
    logic [3:0]  r_pcs;
    logic [3:0]  r_octs;

    // stage d1: divide by 125 estimate
    logic [62:0] qq_prod;
    assign qq_prod = 63'(r_v8s) * 63'(MHZ_RECIP);

    logic        r_vd;
    logic        r_satd;
    logic [30:0] r_v8d;
    t_freq       r_qqd;
    logic [3:0]  r_pcd;
    logic [3:0]  r_octd;

    // stage d2: correction and output
    logic [30:0] rem_d;
    t_freq       n_freq;
    assign rem_d  = r_v8d - 31'(r_qqd) * 31'(MHZ_DIV);
    assign n_freq = r_satd ? FREQ_MAX : r_qqd + 24'(rem_d >= 31'(MHZ_DIV));

    logic  r_vo;
    t_freq r_freq;
    t_freq r_drive_speed;
    logic [3:0] r_pco;
    logic [3:0] r_octo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vs <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_vm <= i_valid;
            r_vs <= r_vm;
            r_vd <= r_vs;
            r_vo <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod        <= 61'(i_side.b0) * 61'(i_ratio);
        r_shm         <= i_side.sh;
        r_pcm         <= i_side.pc;
        r_octm        <= i_side.oct;
        r_sats        <= (v_round >= SAT_LIMIT);
        r_v8s         <= v_round[33:3];
        r_pcs         <= r_pcm;
        r_octs        <= r_octm;
        r_satd        <= r_sats;
        r_v8d         <= r_v8s;
        r_qqd         <= qq_prod[61:38];
        r_pcd         <= r_pcs;
        r_octd        <= r_octs;
        r_freq        <= n_freq;
        r_drive_speed <= i_drive ? n_freq : '0;
        r_pco         <= r_pcd;
        r_octo        <= r_octd;
    end

    assign o_valid       = r_vo;
    assign o_pc          = r_pco;
    assign o_oct         = r_octo;
    assign o_freq        = r_freq;
    assign o_drive_speed = r_drive_speed;

endmodule

`default_nettype wire

### src/tempered_note_frequency.sv
// tempered note frequency: note and detune in, pitch class, octave and milli-hertz out
// the pipeline has 5 front-end, 36 exponential (12 terms of 3) and 4 scaling stages
// throughput one note per cycle while out of reset, every stage is fully pipelined
// i_rst_n is synchronous: it clears every valid bit and loads register defaults
// busy is high only while reset is held; the receiver cannot stall results
`default_nettype none

`include "assert_macros.svh"

module tempered_note_frequency import tnf_pkg::*; #(
    parameter int unsigned LOWEST_OCTAVE = 2,
    parameter int unsigned NOTE_SPAN     = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [5:0]        i_note_number,
    input  wire logic signed [6:0] i_detune_cents,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [12:0]       i_cfg_data,
    output logic                   o_strobe,
    output logic [3:0]             o_pitch_class,
    output logic [3:0]             o_octave_number,
    output logic [23:0]            o_frequency_mhz,
    output logic [23:0]            o_drive_speed
);

    localparam int unsigned FRONT_LAT = 5;
    localparam int unsigned EXP_LAT   = EXP_TERMS * EXP_STEP_LAT;
    localparam int unsigned SCALE_LAT = 4;
    localparam int unsigned LATENCY   = FRONT_LAT + EXP_LAT + SCALE_LAT;

    // configuration registers, to be written only while the pipeline is empty; the block does not enforce this
    logic [12:0] r_ref_a;
    logic [2:0]  r_temper;
    logic [3:0]  r_root;
    logic        r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_a  <= 13'd4400;
            r_temper <= 3'd0;
            r_root   <= 4'd0;
            r_drive  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_REF_A:  r_ref_a  <= i_cfg_data;
                REG_TEMPER: r_temper <= i_cfg_data[2:0];
                REG_ROOT:   r_root   <= i_cfg_data[3:0];
                REG_DRIVE:  r_drive  <= i_cfg_data[0];
                default:    r_drive  <= r_drive;
            endcase
        end
    end

    // no back-pressure anywhere: a note is taken whenever start is seen out of reset
    logic in_xfer;
    assign busy    = !i_rst_n;
    assign in_xfer = start && !busy;

    // front end: pitch class, octave, temperament offset and exponent argument
    logic  front_valid;
    t_y    front_y;
    t_side front_side;

    tnf_front #(
        .LOWEST_OCTAVE (LOWEST_OCTAVE),
        .NOTE_SPAN     (NOTE_SPAN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_xfer),
        .i_note   (i_note_number),
        .i_detune (i_detune_cents),
        .i_ref    (r_ref_a),
        .i_sel    (r_temper),
        .i_root   (r_root),
        .o_valid  (front_valid),
        .o_y      (front_y),
        .o_side   (front_side)
    );

    // exponential: ratio = e^y in Q1.30, three stages per series term
    logic exp_valid;
    t_q30 exp_ratio;

    tnf_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_y     (front_y),
        .o_valid (exp_valid),
        .o_ratio (exp_ratio)
    );

    // side data waits for the exponential; valid travels inside the chain
    t_side r_side_dly [EXP_LAT];

    always_ff @(posedge i_clk) begin
        r_side_dly[0] <= front_side;
        for (int i = 1; i < EXP_LAT; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
    end

    // final scaling, rounding to milli-hertz, saturation and drive gating
    tnf_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (exp_valid),
        .i_ratio       (exp_ratio),
        .i_side        (r_side_dly[EXP_LAT-1]),
        .i_drive       (r_drive),
        .o_valid       (o_strobe),
        .o_pc          (o_pitch_class),
        .o_oct         (o_octave_number),
        .o_freq        (o_frequency_mhz),
        .o_drive_speed (o_drive_speed)
    );

    // every transfer yields exactly one strobe, a fixed number of cycles later
    `TNF_ASSERT(a_result_follows, in_xfer |-> ##LATENCY o_strobe, "result strobe missing")
    `TNF_ASSERT(a_result_has_cause, o_strobe |-> $past(in_xfer, LATENCY), "strobe without transfer")
    `TNF_ASSERT(a_pc_range, o_strobe |-> (o_pitch_class < 4'd12), "pitch class out of range")
    `TNF_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_strobe, "strobe right after reset")

endmodule

`default_nettype wire
